[rtl/radio_state_residency_energy_defines.svh]
// ----------------------------------------------------------------------------
// Radio state residency energy counter: assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RADIO_STATE_RESIDENCY_ENERGY_DEFINES_SVH
`define RADIO_STATE_RESIDENCY_ENERGY_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define RSRE_ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("rsre check failed");

// next-cycle implication
`define RSRE_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("rsre check failed");

`else

`define RSRE_ASSERT_SAME(lbl, ck, rn, ante, cons)
`define RSRE_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

[rtl/rsre_pkg.sv]
// ----------------------------------------------------------------------------
// rsre_pkg
// Types, codes and constants shared by the residency energy counter.
// ----------------------------------------------------------------------------
package rsre_pkg;

    localparam int NODE_W   = 5;
    localparam int TIME_W   = 36;
    localparam int POWER_W  = 20;
    localparam int ENERGY_W = 58;
    localparam int PHY_W    = 3;
    localparam int CFG_IDX_W = 2;

    // energy is built from 18-bit halves of each total
    localparam int HALF_W    = 18;
    localparam int PROD_W    = POWER_W + HALF_W;
    localparam int MAC_STEPS = 8;
    localparam int STEP_W    = $clog2(MAC_STEPS + 1);

    localparam logic [POWER_W-1:0] TX_POWER_RST   = 20'd52200;
    localparam logic [POWER_W-1:0] RX_POWER_RST   = 20'd59100;
    localparam logic [POWER_W-1:0] IDLE_POWER_RST = 20'd1278;
    localparam logic [POWER_W-1:0] OFF_POWER_RST  = 20'd60;

    typedef enum logic [1:0] {
        CLS_TX   = 2'd0,
        CLS_RX   = 2'd1,
        CLS_IDLE = 2'd2,
        CLS_OFF  = 2'd3
    } pwr_class_t;

    typedef enum logic [PHY_W-1:0] {
        PHY_BUSY_TX   = 3'd0,
        PHY_BUSY_RX   = 3'd1,
        PHY_IDLE      = 3'd2,
        PHY_RX_ON     = 3'd3,
        PHY_TX_ON     = 3'd4,
        PHY_TRX_OFF   = 3'd5,
        PHY_FORCE_OFF = 3'd6,
        PHY_OTHER     = 3'd7
    } phy_state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TX_POWER   = 2'd0,
        REG_RX_POWER   = 2'd1,
        REG_IDLE_POWER = 2'd2,
        REG_OFF_POWER  = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        MODE_CHANGE = 1'b0,
        MODE_CLOSE  = 1'b1
    } mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DELTA,
        ST_ACCUM,
        ST_MAC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              mode;
        logic [NODE_W-1:0] node;
        logic [TIME_W-1:0] time_us;
        logic [PHY_W-1:0]  phy_state;
    } in_item_t;

    typedef struct packed {
        logic [NODE_W-1:0]   out_node;
        logic [TIME_W-1:0]   tx_time_us;
        logic [TIME_W-1:0]   rx_time_us;
        logic [TIME_W-1:0]   idle_time_us;
        logic [TIME_W-1:0]   off_time_us;
        logic [ENERGY_W-1:0] energy_pj;
    } out_item_t;

    // one node's table entry
    typedef struct packed {
        logic [TIME_W-1:0] last_time;
        pwr_class_t        last_class;
        logic [TIME_W-1:0] tx_total;
        logic [TIME_W-1:0] rx_total;
        logic [TIME_W-1:0] idle_total;
        logic [TIME_W-1:0] off_total;
    } entry_t;

    localparam entry_t ENTRY_RST = '{
        last_time:  '0,
        last_class: CLS_OFF,
        tx_total:   '0,
        rx_total:   '0,
        idle_total: '0,
        off_total:  '0
    };

    // map a phy state onto its power class; every other state counts as idle
    function automatic pwr_class_t class_of(input logic [PHY_W-1:0] phy);
        pwr_class_t cls;
        unique case (phy) inside
            PHY_BUSY_TX:                cls = CLS_TX;
            PHY_BUSY_RX:                cls = CLS_RX;
            PHY_TRX_OFF, PHY_FORCE_OFF: cls = CLS_OFF;
            default:                    cls = CLS_IDLE;
        endcase
        return cls;
    endfunction

endpackage

[rtl/rsre_table.sv]
// ----------------------------------------------------------------------------
// rsre_table
// Per-node entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rsre_table #(
    parameter int NODES = 32
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [$clog2(NODES)-1:0]    wr_addr,
    input  rsre_pkg::entry_t            wr_data,
    input  logic                        rd_en,
    input  logic [$clog2(NODES)-1:0]    rd_addr,
    output rsre_pkg::entry_t            rd_data
);

    rsre_pkg::entry_t mem [NODES];
    rsre_pkg::entry_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/rsre_mac.sv]
// ----------------------------------------------------------------------------
// rsre_mac
// Shared multiply-accumulate: power times one 18-bit half of a total per
// issue, product registered, then added into the energy sum.
// ----------------------------------------------------------------------------
module rsre_mac (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             clr,
    input  logic                             issue,
    input  logic                             hi,
    input  logic [rsre_pkg::POWER_W-1:0]     a,
    input  logic [rsre_pkg::HALF_W-1:0]      b,
    output logic [rsre_pkg::ENERGY_W-1:0]    acc
);

    logic                          vld_reg;
    logic                          hi_reg;
    logic [rsre_pkg::PROD_W-1:0]   prod_reg;
    logic [rsre_pkg::ENERGY_W-1:0] acc_reg;
    logic [rsre_pkg::ENERGY_W-1:0] addend;

    // multiply stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            hi_reg  <= 1'b0;
        end
        else
        begin
            vld_reg <= issue;
            hi_reg  <= hi;
        end
    end

    // multiply stage
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            prod_reg <= rsre_pkg::PROD_W'(a) * rsre_pkg::PROD_W'(b);
        end
    end

    // align the product to its half
    always_comb
    begin
        if (hi_reg)
        begin
            addend = rsre_pkg::ENERGY_W'({prod_reg, {rsre_pkg::HALF_W{1'b0}}});
        end
        else
        begin
            addend = rsre_pkg::ENERGY_W'(prod_reg);
        end
    end

    // accumulate stage
    always_ff @(posedge clk)
    begin
        if (clr)
        begin
            acc_reg <= '0;
        end
        else if (vld_reg)
        begin
            acc_reg <= acc_reg + addend;
        end
    end

    assign acc = acc_reg;

endmodule

[rtl/radio_state_residency_energy.sv]
// ----------------------------------------------------------------------------
// radio_state_residency_energy
// Per-node radio power-state residency counters with energy readout.
// ----------------------------------------------------------------------------
// After reset the block sweeps its node table once, one entry a cycle, and
// takes no item until the sweep is done; configuration writes are taken
// throughout. A state-change event is a read-modify-write of one table
// entry: accept, time delta, then saturating add and write-back. A close
// event then runs the shared 20x18 multiply-accumulate unit, which forms the
// energy from eight partial products, and then loads the output register.
// Nodes at or above NODES are dropped without a result. Energy is in
// picojoules (microwatts times microseconds); each residency total saturates
// at its full 36-bit range.
// ----------------------------------------------------------------------------
`include "radio_state_residency_energy_defines.svh"

module radio_state_residency_energy #(
    parameter int NODES = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [rsre_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rsre_pkg::POWER_W-1:0]       cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  rsre_pkg::in_item_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output rsre_pkg::out_item_t                out_data
);

    localparam int IDX_W = $clog2(NODES);
    localparam int EXT_W = IDX_W + rsre_pkg::NODE_W;

    rsre_pkg::state_t   state_reg;
    rsre_pkg::state_t   state_next;

    logic [rsre_pkg::POWER_W-1:0] pwr_reg [4];
    logic [IDX_W-1:0]             clr_cnt_reg;
    rsre_pkg::in_item_t           item_reg;
    logic [rsre_pkg::TIME_W-1:0]  dt_reg;
    logic [rsre_pkg::TIME_W-1:0]  tot_reg [4];
    logic [rsre_pkg::STEP_W-1:0]  step_reg;
    logic                         out_valid_reg;
    rsre_pkg::out_item_t          out_data_reg;

    logic                         in_xfer;
    logic                         out_xfer;
    logic [EXT_W-1:0]             in_node_ext;
    logic [EXT_W-1:0]             item_node_ext;
    logic                         node_ok;
    logic [IDX_W-1:0]             in_idx;
    logic [IDX_W-1:0]             item_idx;
    logic                         out_free;

    rsre_pkg::entry_t             rd_ent;
    rsre_pkg::entry_t             wr_ent;
    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr;
    logic [rsre_pkg::TIME_W-1:0]  old_total;
    logic [rsre_pkg::TIME_W:0]    sum_wide;
    logic [rsre_pkg::TIME_W-1:0]  new_total;

    logic                         mac_clr;
    logic                         mac_issue;
    logic [rsre_pkg::HALF_W-1:0]  mac_b;
    logic [rsre_pkg::ENERGY_W-1:0] energy;

    // handshakes
    assign in_stall  = (state_reg != rsre_pkg::ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // node index and range check
    assign in_node_ext   = EXT_W'(in_data.node);
    assign item_node_ext = EXT_W'(item_reg.node);
    assign node_ok       = (in_node_ext < EXT_W'(NODES));
    assign in_idx        = in_node_ext[IDX_W-1:0];
    assign item_idx      = item_node_ext[IDX_W-1:0];

    // power registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwr_reg[rsre_pkg::REG_TX_POWER]   <= rsre_pkg::TX_POWER_RST;
            pwr_reg[rsre_pkg::REG_RX_POWER]   <= rsre_pkg::RX_POWER_RST;
            pwr_reg[rsre_pkg::REG_IDLE_POWER] <= rsre_pkg::IDLE_POWER_RST;
            pwr_reg[rsre_pkg::REG_OFF_POWER]  <= rsre_pkg::OFF_POWER_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                rsre_pkg::REG_TX_POWER:   pwr_reg[rsre_pkg::REG_TX_POWER]   <= cfg_wdata;
                rsre_pkg::REG_RX_POWER:   pwr_reg[rsre_pkg::REG_RX_POWER]   <= cfg_wdata;
                rsre_pkg::REG_IDLE_POWER: pwr_reg[rsre_pkg::REG_IDLE_POWER] <= cfg_wdata;
                rsre_pkg::REG_OFF_POWER:  pwr_reg[rsre_pkg::REG_OFF_POWER]  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rsre_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rsre_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == IDX_W'(NODES - 1))
                begin
                    state_next = rsre_pkg::ST_IDLE;
                end
            end
            rsre_pkg::ST_IDLE:
            begin
                if (in_xfer && node_ok)
                begin
                    state_next = rsre_pkg::ST_DELTA;
                end
            end
            rsre_pkg::ST_DELTA:
            begin
                state_next = rsre_pkg::ST_ACCUM;
            end
            rsre_pkg::ST_ACCUM:
            begin
                if (item_reg.mode == rsre_pkg::MODE_CLOSE)
                begin
                    state_next = rsre_pkg::ST_MAC;
                end
                else
                begin
                    state_next = rsre_pkg::ST_IDLE;
                end
            end
            rsre_pkg::ST_MAC:
            begin
                if (step_reg == rsre_pkg::STEP_W'(rsre_pkg::MAC_STEPS))
                begin
                    state_next = rsre_pkg::ST_OUT;
                end
            end
            rsre_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = rsre_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rsre_pkg::ST_CLEAR;
            end
        endcase
    end

    // clearing sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (state_reg == rsre_pkg::ST_CLEAR)
        begin
            clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
        end
    end

    // hold the accepted item
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg <= in_data;
        end
    end

    // elapsed time, zero when time went backwards
    always_ff @(posedge clk)
    begin
        if (state_reg == rsre_pkg::ST_DELTA)
        begin
            if (item_reg.time_us >= rd_ent.last_time)
            begin
                dt_reg <= item_reg.time_us - rd_ent.last_time;
            end
            else
            begin
                dt_reg <= '0;
            end
        end
    end

    // saturating add into the old class's total
    always_comb
    begin
        case (rd_ent.last_class)
            rsre_pkg::CLS_TX:   old_total = rd_ent.tx_total;
            rsre_pkg::CLS_RX:   old_total = rd_ent.rx_total;
            rsre_pkg::CLS_IDLE: old_total = rd_ent.idle_total;
            default:            old_total = rd_ent.off_total;
        endcase
        sum_wide = {1'b0, old_total} + {1'b0, dt_reg};
        if (sum_wide[rsre_pkg::TIME_W])
        begin
            new_total = '1;
        end
        else
        begin
            new_total = sum_wide[rsre_pkg::TIME_W-1:0];
        end
    end

    // build the write-back entry
    always_comb
    begin
        wr_ent           = rd_ent;
        wr_ent.last_time = item_reg.time_us;
        case (rd_ent.last_class)
            rsre_pkg::CLS_TX:   wr_ent.tx_total   = new_total;
            rsre_pkg::CLS_RX:   wr_ent.rx_total   = new_total;
            rsre_pkg::CLS_IDLE: wr_ent.idle_total = new_total;
            default:            wr_ent.off_total  = new_total;
        endcase
        if (item_reg.mode == rsre_pkg::MODE_CHANGE)
        begin
            wr_ent.last_class = rsre_pkg::class_of(item_reg.phy_state);
        end
        if (state_reg == rsre_pkg::ST_CLEAR)
        begin
            wr_ent  = rsre_pkg::ENTRY_RST;
            wr_addr = clr_cnt_reg;
        end
        else
        begin
            wr_addr = item_idx;
        end
        wr_en = (state_reg == rsre_pkg::ST_CLEAR) || (state_reg == rsre_pkg::ST_ACCUM);
    end

    rsre_table #(
        .NODES (NODES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_ent),
        .rd_en   (in_xfer),
        .rd_addr (in_idx),
        .rd_data (rd_ent)
    );

    // capture the updated totals for readout
    always_ff @(posedge clk)
    begin
        if (state_reg == rsre_pkg::ST_ACCUM)
        begin
            tot_reg[rsre_pkg::CLS_TX]   <= wr_ent.tx_total;
            tot_reg[rsre_pkg::CLS_RX]   <= wr_ent.rx_total;
            tot_reg[rsre_pkg::CLS_IDLE] <= wr_ent.idle_total;
            tot_reg[rsre_pkg::CLS_OFF]  <= wr_ent.off_total;
        end
    end

    // energy sequencer step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (state_reg == rsre_pkg::ST_ACCUM)
        begin
            step_reg <= '0;
        end
        else if (state_reg == rsre_pkg::ST_MAC)
        begin
            step_reg <= step_reg + rsre_pkg::STEP_W'(1);
        end
    end

    // select power and total half for this step
    assign mac_clr   = (state_reg == rsre_pkg::ST_ACCUM);
    assign mac_issue = (state_reg == rsre_pkg::ST_MAC) &&
                       (step_reg < rsre_pkg::STEP_W'(rsre_pkg::MAC_STEPS));
    assign mac_b     = step_reg[0] ?
                       tot_reg[step_reg[2:1]][rsre_pkg::TIME_W-1:rsre_pkg::HALF_W] :
                       tot_reg[step_reg[2:1]][rsre_pkg::HALF_W-1:0];

    rsre_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (mac_clr),
        .issue (mac_issue),
        .hi    (step_reg[0]),
        .a     (pwr_reg[step_reg[2:1]]),
        .b     (mac_b),
        .acc   (energy)
    );

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == rsre_pkg::ST_OUT && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (state_reg == rsre_pkg::ST_OUT && out_free)
        begin
            out_data_reg.out_node     <= item_reg.node;
            out_data_reg.tx_time_us   <= tot_reg[rsre_pkg::CLS_TX];
            out_data_reg.rx_time_us   <= tot_reg[rsre_pkg::CLS_RX];
            out_data_reg.idle_time_us <= tot_reg[rsre_pkg::CLS_IDLE];
            out_data_reg.off_time_us  <= tot_reg[rsre_pkg::CLS_OFF];
            out_data_reg.energy_pj    <= energy;
        end
    end

    `RSRE_ASSERT_SAME(a_rise_from_out, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == rsre_pkg::ST_OUT)
    `RSRE_ASSERT_SAME(a_step_bound, clk, rst_n, state_reg == rsre_pkg::ST_MAC, step_reg <= rsre_pkg::STEP_W'(rsre_pkg::MAC_STEPS))
    `RSRE_ASSERT_NEXT(a_accept_delta, clk, rst_n, in_xfer && node_ok, state_reg == rsre_pkg::ST_DELTA)
    `RSRE_ASSERT_SAME(a_no_out_in_clear, clk, rst_n, state_reg == rsre_pkg::ST_CLEAR, !out_valid_reg)

endmodule

[tb/radio_state_residency_energy_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Residency energy scoreboard
// Watches the power register port and both item channels, keeps its own copy
// of the per-node residency table, and checks every readout transfer in order.
// ----------------------------------------------------------------------------
module radio_state_residency_energy_checker #(
    parameter int NODES = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [rsre_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rsre_pkg::POWER_W-1:0]   cfg_wdata,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  rsre_pkg::in_item_t             in_data,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  rsre_pkg::out_item_t            out_data,
    output int                             mismatches,
    output int                             pending
);

    localparam int IDX_W = $clog2(NODES);
    localparam logic [rsre_pkg::TIME_W-1:0] TIME_MAX = '1;

    logic [rsre_pkg::POWER_W-1:0] tx_pw;
    logic [rsre_pkg::POWER_W-1:0] rx_pw;
    logic [rsre_pkg::POWER_W-1:0] idle_pw;
    logic [rsre_pkg::POWER_W-1:0] off_pw;

    logic [rsre_pkg::TIME_W-1:0] seen_time  [NODES];
    rsre_pkg::pwr_class_t        seen_class [NODES];
    logic [rsre_pkg::TIME_W-1:0] tx_acc     [NODES];
    logic [rsre_pkg::TIME_W-1:0] rx_acc     [NODES];
    logic [rsre_pkg::TIME_W-1:0] idle_acc   [NODES];
    logic [rsre_pkg::TIME_W-1:0] off_acc    [NODES];

    rsre_pkg::out_item_t readouts_due [$];

    function automatic rsre_pkg::pwr_class_t phy_to_class(
        input logic [rsre_pkg::PHY_W-1:0] phy);
        case (phy) inside
            rsre_pkg::PHY_BUSY_TX:                          return rsre_pkg::CLS_TX;
            rsre_pkg::PHY_BUSY_RX:                          return rsre_pkg::CLS_RX;
            rsre_pkg::PHY_TRX_OFF, rsre_pkg::PHY_FORCE_OFF: return rsre_pkg::CLS_OFF;
            default:                                        return rsre_pkg::CLS_IDLE;
        endcase
    endfunction

    function automatic logic [rsre_pkg::TIME_W-1:0] sat_sum(
        input logic [rsre_pkg::TIME_W-1:0] a,
        input logic [rsre_pkg::TIME_W-1:0] b);
        logic [rsre_pkg::TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[rsre_pkg::TIME_W] ? TIME_MAX : s[rsre_pkg::TIME_W-1:0];
    endfunction

    // charge elapsed time to the old class, then record the event
    task automatic account_event(input rsre_pkg::in_item_t it);
        int                          n;
        logic [IDX_W-1:0]            idx;
        logic [rsre_pkg::TIME_W-1:0] dt;
        logic [63:0]                 energy;
        rsre_pkg::out_item_t         res;
        n = int'(it.node);
        if (n >= NODES)
            return;
        idx = IDX_W'(n);
        if (it.time_us >= seen_time[idx])
        begin
            dt = it.time_us - seen_time[idx];
            case (seen_class[idx])
                rsre_pkg::CLS_TX:   tx_acc[idx]   = sat_sum(tx_acc[idx], dt);
                rsre_pkg::CLS_RX:   rx_acc[idx]   = sat_sum(rx_acc[idx], dt);
                rsre_pkg::CLS_IDLE: idle_acc[idx] = sat_sum(idle_acc[idx], dt);
                default:            off_acc[idx]  = sat_sum(off_acc[idx], dt);
            endcase
        end
        seen_time[idx] = it.time_us;
        if (it.mode == rsre_pkg::MODE_CHANGE)
        begin
            seen_class[idx] = phy_to_class(it.phy_state);
        end
        else
        begin
            energy = 64'(tx_pw) * 64'(tx_acc[idx]) + 64'(rx_pw) * 64'(rx_acc[idx])
                   + 64'(idle_pw) * 64'(idle_acc[idx]) + 64'(off_pw) * 64'(off_acc[idx]);
            res.out_node     = it.node;
            res.tx_time_us   = tx_acc[idx];
            res.rx_time_us   = rx_acc[idx];
            res.idle_time_us = idle_acc[idx];
            res.off_time_us  = off_acc[idx];
            res.energy_pj    = energy[rsre_pkg::ENERGY_W-1:0];
            readouts_due     = {readouts_due, res};
        end
    endtask

    task automatic compare_field(input string label, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
            mismatches++;
        end
    endtask

    task automatic check_readout(input rsre_pkg::out_item_t got);
        rsre_pkg::out_item_t want;
        if (readouts_due.size() == 0)
        begin
            $display("%0t: readout with none expected, expected nothing, got node %0d",
                     $time, got.out_node);
            mismatches++;
            return;
        end
        want = readouts_due.pop_front();
        compare_field("out_node", 64'(want.out_node), 64'(got.out_node));
        compare_field("tx_time_us", 64'(want.tx_time_us), 64'(got.tx_time_us));
        compare_field("rx_time_us", 64'(want.rx_time_us), 64'(got.rx_time_us));
        compare_field("idle_time_us", 64'(want.idle_time_us), 64'(got.idle_time_us));
        compare_field("off_time_us", 64'(want.off_time_us), 64'(got.off_time_us));
        compare_field("energy_pj", 64'(want.energy_pj), 64'(got.energy_pj));
    endtask

    // track writes, transfers in and transfers out on each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_pw   = rsre_pkg::TX_POWER_RST;
            rx_pw   = rsre_pkg::RX_POWER_RST;
            idle_pw = rsre_pkg::IDLE_POWER_RST;
            off_pw  = rsre_pkg::OFF_POWER_RST;
            for (int i = 0; i < NODES; i++)
            begin
                seen_time[i]  = '0;
                seen_class[i] = rsre_pkg::CLS_OFF;
                tx_acc[i]     = '0;
                rx_acc[i]     = '0;
                idle_acc[i]   = '0;
                off_acc[i]    = '0;
            end
            readouts_due.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    rsre_pkg::REG_TX_POWER:   tx_pw   = cfg_wdata;
                    rsre_pkg::REG_RX_POWER:   rx_pw   = cfg_wdata;
                    rsre_pkg::REG_IDLE_POWER: idle_pw = cfg_wdata;
                    rsre_pkg::REG_OFF_POWER:  off_pw  = cfg_wdata;
                    default:                  ;
                endcase
            end
            if (in_valid && !in_stall)
                account_event(in_data);
            if (out_valid && !out_stall)
                check_readout(out_data);
            pending = readouts_due.size();
        end
    end

endmodule

[tb/radio_state_residency_energy_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Residency energy counter testbench
// Drives directed and random radio events with random gaps and output stalls
// across several power settings; the scoreboard checks every readout.
// ----------------------------------------------------------------------------
module radio_state_residency_energy_tb;

    localparam int NODES        = 32;
    localparam int LIMIT        = 1_000_000;
    localparam int SETTLE       = 20;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 250;
    localparam logic [rsre_pkg::TIME_W-1:0]  TIME_MAX  = '1;
    localparam logic [rsre_pkg::POWER_W-1:0] POWER_MAX = '1;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [rsre_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rsre_pkg::POWER_W-1:0]   cfg_wdata;
    logic                           in_valid;
    logic                           in_stall;
    rsre_pkg::in_item_t             in_data;
    logic                           out_valid;
    logic                           out_stall;
    rsre_pkg::out_item_t            out_data;
    int                             mismatches;
    int                             pending;

    logic [rsre_pkg::TIME_W-1:0] node_clock [NODES];
    bit                          gaps_on;
    int                          hold_left;
    int                          stall_regime;
    int                          regime_left;

    radio_state_residency_energy #(
        .NODES(NODES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    radio_state_residency_energy_checker #(
        .NODES(NODES)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [rsre_pkg::TIME_W-1:0] rand_time();
        logic [rsre_pkg::TIME_W-1:0] t;
        t[31:0]                  = $urandom();
        t[rsre_pkg::TIME_W-1:32] = (rsre_pkg::TIME_W - 32)'($urandom_range(0, 15));
        return t;
    endfunction

    function automatic rsre_pkg::in_item_t make_item(input rsre_pkg::mode_t m, input int n,
                                                     input logic [rsre_pkg::TIME_W-1:0] t,
                                                     input rsre_pkg::phy_state_t p);
        rsre_pkg::in_item_t it;
        it.mode      = m;
        it.node      = n[rsre_pkg::NODE_W-1:0];
        it.time_us   = t;
        it.phy_state = p;
        return it;
    endfunction

    // stall the readout channel in stretches: none, light or heavy
    always @(posedge clk)
    begin
        if (regime_left == 0)
        begin
            stall_regime = $urandom_range(0, 2);
            regime_left  = $urandom_range(50, 400);
        end
        else
        begin
            regime_left--;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_regime != 0 && $urandom_range(0, 99) < 20 * stall_regime)
        begin
            hold_left = gap_len() - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // hold valid across back-to-back items; drop it only for a gap
    task automatic send(input rsre_pkg::in_item_t it);
        int gap;
        gap = (gaps_on && $urandom_range(0, 9) < 4) ? gap_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        node_clock[it.node] = it.time_us;
        do @(posedge clk); while (in_stall);
    endtask

    // wait out every readout, then let a trailing state change settle
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_powers(input logic [rsre_pkg::POWER_W-1:0] tx,
                              input logic [rsre_pkg::POWER_W-1:0] rx,
                              input logic [rsre_pkg::POWER_W-1:0] idle,
                              input logic [rsre_pkg::POWER_W-1:0] off);
        cfg_wr_en <= 1'b1;
        cfg_index <= rsre_pkg::REG_TX_POWER;
        cfg_wdata <= tx;
        @(posedge clk);
        cfg_index <= rsre_pkg::REG_RX_POWER;
        cfg_wdata <= rx;
        @(posedge clk);
        cfg_index <= rsre_pkg::REG_IDLE_POWER;
        cfg_wdata <= idle;
        @(posedge clk);
        cfg_index <= rsre_pkg::REG_OFF_POWER;
        cfg_wdata <= off;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [rsre_pkg::POWER_W-1:0] rand_power();
        return rsre_pkg::POWER_W'($urandom_range(0, POWER_MAX));
    endfunction

    initial
    begin : watchdog
        repeat (LIMIT) @(posedge clk);
        $display("radio_state_residency_energy_tb failed");
        $finish;
    end

    initial
    begin : stimulus
        int                          n;
        int                          r;
        rsre_pkg::mode_t             m;
        logic [rsre_pkg::TIME_W-1:0] step;
        logic [rsre_pkg::TIME_W-1:0] t;
        logic [rsre_pkg::TIME_W:0]   sum;

        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = rsre_pkg::REG_TX_POWER;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_stall    = 1'b0;
        gaps_on      = 1'b1;
        hold_left    = 0;
        stall_regime = 0;
        regime_left  = 0;
        for (int i = 0; i < NODES; i++)
            node_clock[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // read out untouched nodes, with and without elapsed off time
        send(make_item(rsre_pkg::MODE_CLOSE, 0, '0, rsre_pkg::PHY_BUSY_TX));
        send(make_item(rsre_pkg::MODE_CLOSE, 1, 36'd1000, rsre_pkg::PHY_OTHER));

        // walk one node through every phy state
        send(make_item(rsre_pkg::MODE_CHANGE, 2, 36'd100, rsre_pkg::PHY_BUSY_TX));
        send(make_item(rsre_pkg::MODE_CHANGE, 2, 36'd300, rsre_pkg::PHY_BUSY_RX));
        send(make_item(rsre_pkg::MODE_CHANGE, 2, 36'd450, rsre_pkg::PHY_IDLE));
        send(make_item(rsre_pkg::MODE_CHANGE, 2, 36'd500, rsre_pkg::PHY_RX_ON));
        send(make_item(rsre_pkg::MODE_CHANGE, 2, 36'd520, rsre_pkg::PHY_TX_ON));
        send(make_item(rsre_pkg::MODE_CHANGE, 2, 36'd530, rsre_pkg::PHY_TRX_OFF));
        send(make_item(rsre_pkg::MODE_CHANGE, 2, 36'd600, rsre_pkg::PHY_FORCE_OFF));
        send(make_item(rsre_pkg::MODE_CHANGE, 2, 36'd640, rsre_pkg::PHY_OTHER));
        send(make_item(rsre_pkg::MODE_CLOSE, 2, 36'd700, rsre_pkg::PHY_BUSY_TX));

        // time going backwards adds nothing but still moves the class
        send(make_item(rsre_pkg::MODE_CHANGE, 3, 36'd5000, rsre_pkg::PHY_BUSY_TX));
        send(make_item(rsre_pkg::MODE_CHANGE, 3, 36'd4000, rsre_pkg::PHY_BUSY_RX));
        send(make_item(rsre_pkg::MODE_CLOSE, 3, 36'd4500, rsre_pkg::PHY_IDLE));
        send(make_item(rsre_pkg::MODE_CLOSE, 3, 36'd4500, rsre_pkg::PHY_IDLE));

        // push the transmit total into saturation
        send(make_item(rsre_pkg::MODE_CHANGE, 31, '0, rsre_pkg::PHY_BUSY_TX));
        send(make_item(rsre_pkg::MODE_CLOSE, 31, TIME_MAX, rsre_pkg::PHY_FORCE_OFF));
        send(make_item(rsre_pkg::MODE_CHANGE, 31, '0, rsre_pkg::PHY_BUSY_TX));
        send(make_item(rsre_pkg::MODE_CLOSE, 31, TIME_MAX, rsre_pkg::PHY_OTHER));
        send(make_item(rsre_pkg::MODE_CLOSE, 31, TIME_MAX, rsre_pkg::PHY_OTHER));
        drain();

        // largest energy, then none at all
        set_powers(POWER_MAX, POWER_MAX, POWER_MAX, POWER_MAX);
        send(make_item(rsre_pkg::MODE_CLOSE, 31, TIME_MAX, rsre_pkg::PHY_BUSY_RX));
        send(make_item(rsre_pkg::MODE_CLOSE, 2, 36'd800, rsre_pkg::PHY_BUSY_RX));
        drain();
        set_powers('0, '0, '0, '0);
        send(make_item(rsre_pkg::MODE_CLOSE, 31, TIME_MAX, rsre_pkg::PHY_BUSY_RX));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            case (phase)
                0:       set_powers(rand_power(), rand_power(), rand_power(), rand_power());
                1:       set_powers('0, POWER_MAX, '0, POWER_MAX);
                2:       set_powers(rsre_pkg::TX_POWER_RST, rsre_pkg::RX_POWER_RST,
                                    rsre_pkg::IDLE_POWER_RST, rsre_pkg::OFF_POWER_RST);
                3:       set_powers(POWER_MAX, '0, POWER_MAX, '0);
                default: set_powers(rand_power(), rand_power(), rand_power(), rand_power());
            endcase

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // switch idling on and off in stretches
                if (k % 40 == 0)
                    gaps_on = ($urandom_range(0, 2) != 0);
                n = $urandom_range(0, NODES - 1);
                r = $urandom_range(0, 99);
                if (r < 80)
                begin
                    // advance the node's clock, mostly by small steps
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        step = rsre_pkg::TIME_W'($urandom_range(0, 5000));
                    else if (r < 90)
                        step = rsre_pkg::TIME_W'($urandom());
                    else
                        step = rand_time();
                    sum = {1'b0, node_clock[n[rsre_pkg::NODE_W-1:0]]} + {1'b0, step};
                    t   = sum[rsre_pkg::TIME_W] ? TIME_MAX : sum[rsre_pkg::TIME_W-1:0];
                end
                else
                begin
                    // arbitrary time, often behind the node's last event
                    t = rand_time();
                end
                m = ($urandom_range(0, 3) == 0) ? rsre_pkg::MODE_CLOSE : rsre_pkg::MODE_CHANGE;
                send(make_item(m, n, t, rsre_pkg::phy_state_t'($urandom_range(0, 7))));
            end
        end
        drain();

        if (mismatches == 0)
            $display("radio_state_residency_energy_tb passed");
        else
            $display("radio_state_residency_energy_tb failed");
        $finish;
    end

endmodule
